[src/sha256_sh_pkg.sv]
// sha-256 stream hasher shared types and constants
package sha256_sh_pkg;

  typedef struct packed {
    logic [7:0] message_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_position;
    logic        last_word;
  } out_req_t;

  localparam logic [7:0] PadByte = 8'h80;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h;
    unique case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

[src/sha256_stream_hasher_core.sv]
// sha-256 stream hasher top level
//
// in_ channel: one request per message byte (byte_present) with end_of_message
// marking the last item; a request with byte_present and end_of_message both
// low is accepted and does nothing. out_ channel: on a message end eight
// digest words, word 0 first, last_word on word 7.
// the accept cycle of a byte reads its block word, the next one writes the
// merged word back. the 64th byte of a block adds a compression: a load of
// the working registers and a memory read, 64 rounds at one per cycle with
// the schedule in a 16-word shift window fed from the block memory, then a
// fold of the eight working registers into the chain. a message end adds
// the pad byte, one memory write per remaining word, one or two compressions
// and 8 result words at one per cycle at best; in_ready stays low until the
// last one is taken, and a stalled receiver holds the current word unchanged.
// after reset, and after each digest, the chain holds the initial hash values
// and the length counter and fill position are zero; no clearing pass is needed.
module sha256_stream_hasher_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  sha256_sh_pkg::in_req_t    in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output sha256_sh_pkg::out_req_t   out_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_BYTE_WR, S_PAD_RD, S_PAD_WR, S_CMP_INIT, S_ROUND_RD, S_ROUND,
    S_FOLD, S_OUT
  } state_t;

  state_t       state_r;
  logic [31:0]  blk_mem [16];
  logic [31:0]  blk_rd_r;
  logic [31:0]  ch_r [8];
  logic [31:0]  wr_r [8];
  logic [5:0]   fill_r;
  logic [63:0]  bits_r;
  logic [7:0]   byte_r;
  logic         eom_r;
  logic         final_r;
  logic         len_here_r;
  logic [6:0]   rnd_r;
  logic [2:0]   idx_r;
  logic [31:0]  wt_r [16];

  // memory port
  logic         mem_we;
  logic [3:0]   mem_wa;
  logic [31:0]  mem_wd;
  logic [3:0]   mem_ra;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      blk_mem[mem_wa] <= mem_wd;
    end
    blk_rd_r <= blk_mem[mem_ra];
  end

  logic [31:0] pad_word;
  logic [31:0] w_new;
  logic [31:0] w_cur;
  logic [31:0] s0, s1, t1, t2, big0, big1, chv, maj;
  logic [5:0]  rnd6;

  assign rnd6 = rnd_r[5:0];

  always_comb begin
    logic [31:0] x, y;
    x = wt_r[1];
    y = wt_r[14];
    s0 = sha256_sh_pkg::rotr(x, 7) ^ sha256_sh_pkg::rotr(x, 18) ^ (x >> 3);
    s1 = sha256_sh_pkg::rotr(y, 17) ^ sha256_sh_pkg::rotr(y, 19) ^ (y >> 10);
    w_new = wt_r[0] + s0 + wt_r[9] + s1;
    w_cur = (rnd_r < 7'd16) ? blk_rd_r : w_new;
    big1 = sha256_sh_pkg::rotr(wr_r[4], 6) ^ sha256_sh_pkg::rotr(wr_r[4], 11)
         ^ sha256_sh_pkg::rotr(wr_r[4], 25);
    chv = (wr_r[4] & wr_r[5]) ^ (~wr_r[4] & wr_r[6]);
    t1 = wr_r[7] + big1 + chv + sha256_sh_pkg::round_k(rnd6) + w_cur;
    big0 = sha256_sh_pkg::rotr(wr_r[0], 2) ^ sha256_sh_pkg::rotr(wr_r[0], 13)
         ^ sha256_sh_pkg::rotr(wr_r[0], 22);
    maj = (wr_r[0] & wr_r[1]) ^ (wr_r[0] & wr_r[2]) ^ (wr_r[1] & wr_r[2]);
    t2 = big0 + maj;
  end

  // padding word for the current word slot, length in the last two words
  always_comb begin
    pad_word = '0;
    if (len_here_r && fill_r[5:2] == 4'd14) begin
      pad_word = bits_r[63:32];
    end else if (len_here_r && fill_r[5:2] == 4'd15) begin
      pad_word = bits_r[31:0];
    end
  end

  // in-word byte merge
  logic [31:0] merged;
  logic [1:0]  lane;
  logic [31:0] shifted;
  assign lane = fill_r[1:0];
  assign shifted = {24'd0, byte_r} << (5'd24 - {lane, 3'd0});
  assign merged = (lane == 2'd0) ? shifted : (blk_rd_r | shifted);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = fill_r[5:2];
    mem_wd = merged;
    mem_ra = 4'd0;
    unique case (state_r)
      S_IDLE, S_PAD_RD: mem_ra = fill_r[5:2];
      S_BYTE_WR: mem_we = 1'b1;
      S_PAD_WR: begin
        mem_we = 1'b1;
        mem_wd = pad_word;
      end
      S_ROUND: mem_ra = rnd_r[3:0] + 4'd1;
      default: mem_ra = 4'd0;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data.digest_word = ch_r[idx_r];
  assign out_data.word_position = idx_r;
  assign out_data.last_word = (idx_r == 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r <= '0;
      bits_r <= '0;
      eom_r <= 1'b0;
      final_r <= 1'b0;
      len_here_r <= 1'b0;
      rnd_r <= '0;
      idx_r <= '0;
      for (int i = 0; i < 8; i++) begin
        ch_r[i] <= sha256_sh_pkg::init_h(3'(i));
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_data.byte_present) begin
              byte_r <= in_data.message_byte;
              bits_r <= bits_r + 64'd8;
              eom_r <= in_data.end_of_message;
              state_r <= S_BYTE_WR;
            end else if (in_data.end_of_message) begin
              byte_r <= sha256_sh_pkg::PadByte;
              final_r <= 1'b1;
              state_r <= S_BYTE_WR;
            end
          end
        end
        S_BYTE_WR: begin
          if (final_r) begin
            // pad byte written, rest of its word is already zero
            len_here_r <= (fill_r[5:2] <= 4'd13);
            fill_r <= {fill_r[5:2] + 4'd1, 2'd0};
            if (fill_r[5:2] == 4'd15) begin
              state_r <= S_CMP_INIT;
            end else begin
              state_r <= S_PAD_WR;
            end
          end else begin
            fill_r <= fill_r + 6'd1;
            if (fill_r == 6'd63) begin
              state_r <= S_CMP_INIT;
            end else if (eom_r) begin
              byte_r <= sha256_sh_pkg::PadByte;
              eom_r <= 1'b0;
              final_r <= 1'b1;
              state_r <= S_PAD_RD;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_PAD_RD: begin
          state_r <= S_BYTE_WR;
        end
        S_PAD_WR: begin
          fill_r <= {fill_r[5:2] + 4'd1, 2'd0};
          if (fill_r[5:2] == 4'd15) begin
            state_r <= S_CMP_INIT;
          end
        end
        S_CMP_INIT: begin
          for (int i = 0; i < 8; i++) begin
            wr_r[i] <= ch_r[i];
          end
          rnd_r <= '0;
          state_r <= S_ROUND_RD;
        end
        S_ROUND_RD: begin
          state_r <= S_ROUND;
        end
        S_ROUND: begin
          for (int i = 0; i < 15; i++) begin
            wt_r[i] <= wt_r[i + 1];
          end
          wt_r[15] <= w_cur;
          wr_r[7] <= wr_r[6];
          wr_r[6] <= wr_r[5];
          wr_r[5] <= wr_r[4];
          wr_r[4] <= wr_r[3] + t1;
          wr_r[3] <= wr_r[2];
          wr_r[2] <= wr_r[1];
          wr_r[1] <= wr_r[0];
          wr_r[0] <= t1 + t2;
          rnd_r <= rnd_r + 7'd1;
          if (rnd_r == 7'd63) begin
            idx_r <= '0;
            state_r <= S_FOLD;
          end
        end
        S_FOLD: begin
          ch_r[idx_r] <= ch_r[idx_r] + wr_r[idx_r];
          idx_r <= idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            if (final_r) begin
              if (len_here_r) begin
                state_r <= S_OUT;
              end else begin
                len_here_r <= 1'b1;
                state_r <= S_PAD_WR;
              end
            end else if (eom_r) begin
              byte_r <= sha256_sh_pkg::PadByte;
              eom_r <= 1'b0;
              final_r <= 1'b1;
              state_r <= S_BYTE_WR;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_OUT: begin
          if (out_ready) begin
            idx_r <= idx_r + 3'd1;
            if (idx_r == 3'd7) begin
              for (int i = 0; i < 8; i++) begin
                ch_r[i] <= sha256_sh_pkg::init_h(3'(i));
              end
              bits_r <= '0;
              fill_r <= '0;
              final_r <= 1'b0;
              len_here_r <= 1'b0;
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while digest pending");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("digest word changed under stall");
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_data.byte_present && !in_data.end_of_message)
    |=> in_ready)
    else $error("idle item started work");

endmodule

[verif/sha256_stream_hasher_core_tb.sv]
// testbench for the sha-256 stream hasher: random messages against a digest predictor
`timescale 1ns / 100ps

module sha256_stream_hasher_core_tb;

  localparam int unsigned CycleLimit = 600000;

  class digest_scoreboard;
    bit [31:0] chain[8];
    bit [31:0] blk[16];
    bit [5:0]  fill;
    bit [63:0] bit_count;
    sha256_sh_pkg::out_req_t pending_words[$];
    int unsigned errors;
    int unsigned words_seen;
    int unsigned digests;

    function new();
      errors = 0;
      words_seen = 0;
      digests = 0;
      restart();
    endfunction

    function void restart();
      chain = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      fill = 0;
      bit_count = 0;
    endfunction

    function bit [31:0] ror(bit [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void push_byte(bit [7:0] b);
      bit [31:0] sh;
      sh = {24'd0, b} << (24 - 8 * fill[1:0]);
      if (fill[1:0] == 2'd0) blk[fill[5:2]] = sh;
      else blk[fill[5:2]] |= sh;
      fill = fill + 6'd1;
    endfunction

    function void compress();
      bit [31:0] k[64];
      bit [31:0] w[64];
      bit [31:0] r[8];
      bit [31:0] t1, t2, s0, s1;
      k = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
            32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
            32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
            32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
            32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
            32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
            32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
            32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
            32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 16; i < 64; i++) begin
        s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
        s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
        w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      r = chain;
      for (int i = 0; i < 64; i++) begin
        t1 = r[7] + (ror(r[4], 6) ^ ror(r[4], 11) ^ ror(r[4], 25))
           + ((r[4] & r[5]) ^ (~r[4] & r[6])) + k[i] + w[i];
        t2 = (ror(r[0], 2) ^ ror(r[0], 13) ^ ror(r[0], 22))
           + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
        r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
        r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += r[i];
    endfunction

    function void note_request(sha256_sh_pkg::in_req_t req);
      sha256_sh_pkg::out_req_t o;
      if (req.byte_present) begin
        push_byte(req.message_byte);
        bit_count += 64'd8;
        if (fill == 0) compress();
      end
      if (!req.end_of_message) return;
      push_byte(sha256_sh_pkg::PadByte);
      if (fill == 0 || fill > 6'd56) begin
        while (fill != 0) push_byte(8'h00);
        compress();
      end
      while (fill != 6'd56) push_byte(8'h00);
      for (int i = 0; i < 8; i++) push_byte(bit_count[63 - 8 * i -: 8]);
      compress();
      for (int i = 0; i < 8; i++) begin
        o.digest_word = chain[i];
        o.word_position = i[2:0];
        o.last_word = (i == 7);
        pending_words.insert(pending_words.size(), o);
      end
      digests++;
      restart();
    endfunction

    function void check_result(sha256_sh_pkg::out_req_t got);
      sha256_sh_pkg::out_req_t exp_w;
      words_seen++;
      if (pending_words.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected digest word %h", got);
        return;
      end
      exp_w = pending_words.pop_front();
      if (got.digest_word !== exp_w.digest_word || got.word_position !== exp_w.word_position
          || got.last_word !== exp_w.last_word) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp word %h pos %0d last %0b, got word %h pos %0d last %0b",
                   exp_w.digest_word, exp_w.word_position, exp_w.last_word,
                   got.digest_word, got.word_position, got.last_word);
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  sha256_sh_pkg::in_req_t  in_data;
  logic     out_valid;
  logic     out_ready;
  sha256_sh_pkg::out_req_t out_data;

  digest_scoreboard sb;
  int unsigned cycles = 0;
  int unsigned stall_left;
  int unsigned requests_sent;
  bit calm;

  sha256_stream_hasher_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(15);
    if (calm || r < 10) return 0;
    if (r < 15) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(5) == 0) stall_left <= gap_len();
    end
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  task automatic send(input logic [7:0] b, input bit present, input bit eom);
    sha256_sh_pkg::in_req_t req;
    int unsigned gap;
    req.message_byte = b;
    req.byte_present = present;
    req.end_of_message = eom;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
    requests_sent++;
  endtask

  task automatic send_message(input int unsigned len, input bit end_apart);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(15) == 0) send(8'($urandom_range(255)), 1'b0, 1'b0);
      send(8'($urandom_range(255)), 1'b1, (i == len - 1) && !end_apart);
    end
    if (end_apart || len == 0) send(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned lens_hi;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    sb = new();
    requests_sent = 0;
    calm = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty message, idle requests, byte extremes, byte then separate end
    send(8'hff, 1'b0, 1'b1);
    send(8'h00, 1'b0, 1'b0);
    send(8'hff, 1'b0, 1'b0);
    send(8'h00, 1'b1, 1'b1);
    send(8'hff, 1'b1, 1'b1);
    send(8'h61, 1'b1, 1'b0);
    send(8'h62, 1'b1, 1'b0);
    send(8'h63, 1'b1, 1'b1);
    send(8'h55, 1'b1, 1'b0);
    send(8'haa, 1'b1, 1'b0);
    send(8'h00, 1'b0, 1'b1);
    drain();

    // random messages, mostly short, a few across the padding and block boundaries
    while (requests_sent < 170) begin
      calm = ($urandom_range(7) == 0);
      if ($urandom_range(9) == 0) begin
        lens_hi = $urandom_range(3);
        send_message(lens_hi == 0 ? 55 : lens_hi == 1 ? 56 : lens_hi == 2 ? 63 : 64,
                     1'($urandom_range(1)));
      end else begin
        send_message($urandom_range(12), $urandom_range(3) == 0);
      end
      if ($urandom_range(19) == 0) drain();
    end

    drain();
    repeat (200) @(posedge clk);
    $display("sent %0d requests forming %0d messages, checked %0d digest words",
             requests_sent, sb.digests, sb.words_seen);
    $display("mismatches: %0d", sb.errors);
    if (sb.errors == 0 && sb.pending_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
